>>> hw/rtl/bpc_pkg.sv
// Package with widths, constants and types shared by the pressure compensation block.
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int FRAC_BITS = 6;
  localparam int PA_STEP = 5000;
  localparam int OUT_W = 24;
  localparam int OUT_MAX = 24'hFFFFFF;
  localparam int NUM_W = 128;

  // Number of cells in the restoring divider chain, one quotient bit per cell.
  localparam int DIV_CELLS = NUM_W;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_ZERO_DIV = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOW = 2'd0;
  localparam logic [1:0] REG_MID = 2'd1;
  localparam logic [1:0] REG_HIGH = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  // Quantities carried through the divider cells along with the division itself.
  typedef struct packed {
    logic       vld;
    logic       zdiv;
    logic       neg;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] quo;
  } div_tok_t;

endpackage

>>> hw/rtl/bpc_front.sv
// Front pipeline: calibration points, rational terms and the wide fraction.
`timescale 1ns / 1ps
module bpc_front
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [23:0]        raw_pressure,
  input  logic [15:0]        raw_temperature,
  input  logic signed [15:0] coef_low,
  input  logic signed [15:0] coef_mid,
  input  logic signed [15:0] coef_high,
  input  logic signed [15:0] coef_offset,
  output div_tok_t           tok
);

  // Stage 1: centered temperature squared.
  logic               v1_r;
  logic signed [28:0] p1_r;
  logic [31:0]        tt1_r;
  logic signed [16:0] tc;
  assign tc = $signed({1'b0, raw_temperature}) - 17'sd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_vld;
    if (en) begin
      p1_r  <= $signed({1'b0, raw_pressure, 4'b0});
      tt1_r <= 32'(tc * tc);
    end
  end

  // Stage 2: quadratic products.
  logic               v2_r;
  logic signed [28:0] p2_r;
  logic signed [48:0] ql_r, qm_r, qh_r;
  logic signed [31:0] off2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      p2_r   <= p1_r;
      ql_r   <= coef_low * $signed({1'b0, tt1_r});
      qm_r   <= coef_mid * $signed({1'b0, tt1_r});
      qh_r   <= coef_high * $signed({1'b0, tt1_r});
      off2_r <= 32'(coef_offset * 32'sd32768);
    end
  end

  // Rounding of a quadratic term to Q.4, ties toward plus infinity.
  function automatic logic signed [29:0] rq(input logic signed [48:0] x);
    logic signed [49:0] y;
    begin
      y = 50'(x) + 50'sd524288;
      rq = 30'(y >>> 20);
    end
  endfunction

  // Stage 3: the three points.
  logic               v3_r;
  logic signed [28:0] p3_r;
  logic signed [31:0] s0_r, s1_r, s2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      p3_r <= p2_r;
      s0_r <= 32'sd58720256 + 32'(rq(ql_r));
      s1_r <= off2_r + 32'(rq(qm_r));
      s2_r <= 32'sd192937984 + 32'(rq(qh_r));
    end
  end

  // Stage 4: products of pairs of points and linear terms.
  logic               v4_r;
  logic signed [28:0] p4_r;
  logic signed [35:0] d4_r, f2_4_r;
  logic signed [32:0] e4_r;
  logic signed [63:0] s01_r, s12_r, s20_r;
  logic signed [35:0] f1a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      p4_r   <= p3_r;
      d4_r   <= 36'(12 * 36'(s1_r)) - 36'(7 * 36'(s2_r)) - 36'(5 * 36'(s0_r));
      e4_r   <= 33'(s0_r) - 33'(s1_r);
      f2_4_r <= 36'(16 * 36'(s0_r)) - 36'(9 * 36'(s1_r)) - 36'(7 * 36'(p3_r));
      f1a_r  <= 36'(9 * 36'(s0_r)) - 36'(16 * 36'(s1_r));
      s01_r  <= 64'(s0_r * s1_r);
      s12_r  <= 64'(s1_r * s2_r);
      s20_r  <= 64'(s2_r * s0_r);
    end
  end

  // Stage 5: N, F1 and p*D.
  logic               v5_r;
  logic signed [35:0] d5_r, f2_5_r;
  logic signed [32:0] e5_r;
  logic signed [67:0] n5_r, f1_5_r, pd5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
    if (en) begin
      d5_r   <= d4_r;
      e5_r   <= e4_r;
      f2_5_r <= f2_4_r;
      n5_r   <= 68'(12 * 68'(s20_r)) - 68'(7 * 68'(s01_r)) - 68'(5 * 68'(s12_r));
      f1_5_r <= 68'(f1a_r * p4_r) + 68'(7 * 68'(s01_r));
      pd5_r  <= 68'(d4_r * p4_r);
    end
  end

  // Stage 6: G, and the numerator products taken in halves of the wide operand.
  logic               v6_r, zd6_r;
  logic signed [32:0] e6_r;
  logic signed [68:0] g6_r;
  logic signed [70:0] pdl6_r, pnl6_r;
  logic signed [69:0] pdh6_r, pnh6_r;
  logic signed [68:0] g;
  assign g = 69'(n5_r) + 69'(pd5_r);
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
    if (en) begin
      zd6_r  <= (d5_r == '0) || (e5_r == '0) || (g == '0);
      e6_r   <= e5_r;
      g6_r   <= g;
      pdl6_r <= 71'(d5_r * $signed({1'b0, f1_5_r[33:0]}));
      pdh6_r <= 70'(d5_r * $signed(f1_5_r[67:34]));
      pnl6_r <= 71'(f2_5_r * $signed({1'b0, n5_r[33:0]}));
      pnh6_r <= 70'(f2_5_r * $signed(n5_r[67:34]));
    end
  end

  // Stage 7: numerator sum, and the denominator products in halves of G.
  logic                v7_r, zd7_r;
  logic signed [127:0] num7_r;
  logic signed [68:0]  pgl7_r;
  logic signed [66:0]  pgh7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
    if (en) begin
      zd7_r  <= zd6_r;
      num7_r <= (128'(pdh6_r) <<< 34) + 128'(pdl6_r)
              + (128'(pnh6_r) <<< 34) + 128'(pnl6_r);
      pgl7_r <= 69'(e6_r * $signed({1'b0, g6_r[34:0]}));
      pgh7_r <= 67'(e6_r * $signed(g6_r[68:35]));
    end
  end

  // Stage 8: denominator sum.
  logic                v8_r, zd8_r;
  logic signed [127:0] num8_r, den8_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= v7_r;
    if (en) begin
      zd8_r  <= zd7_r;
      num8_r <= num7_r;
      den8_r <= (128'(pgh7_r) <<< 35) + 128'(pgl7_r);
    end
  end

  // Stage 9: magnitudes, sign and scaling by the output step.
  logic [127:0] an, ad;
  assign an = num8_r[127] ? 128'(-num8_r) : 128'(num8_r);
  assign ad = den8_r[127] ? 128'(-den8_r) : 128'(den8_r);
  always_ff @(posedge clk) begin
    if (!rst_n) tok.vld <= 1'b0;
    else if (en) tok.vld <= v8_r;
    if (en) begin
      tok.zdiv <= zd8_r;
      tok.neg  <= num8_r[127] ^ den8_r[127];
      tok.num  <= 128'(an * 128'(PA_STEP << FRAC_BITS));
      tok.den  <= ad;
      tok.rem  <= '0;
      tok.quo  <= '0;
    end
  end

endmodule

>>> hw/rtl/bpc_div_cell.sv
// One cell of the restoring divider chain: one quotient bit per cycle while en is high.
`timescale 1ns / 1ps
module bpc_div_cell
  import bpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  div_tok_t tok_in,
  output div_tok_t tok_out
);

  div_tok_t     tok_nxt;
  logic [NUM_W:0] sh;
  logic [NUM_W:0] diff;

  // Shift in the next numerator bit and try a subtraction.
  always_comb begin
    tok_nxt = tok_in;
    sh   = {tok_in.rem, tok_in.num[NUM_W-1]};
    diff = sh - {1'b0, tok_in.den};
    tok_nxt.num = {tok_in.num[NUM_W-2:0], 1'b0};
    if (!diff[NUM_W]) begin
      tok_nxt.rem = diff[NUM_W-1:0];
      tok_nxt.quo = {tok_in.quo[NUM_W-2:0], 1'b1};
    end else begin
      tok_nxt.rem = sh[NUM_W-1:0];
      tok_nxt.quo = {tok_in.quo[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tok_out.vld <= 1'b0;
    else if (en) tok_out.vld <= tok_nxt.vld;
    if (en) begin
      tok_out.zdiv <= tok_nxt.zdiv;
      tok_out.neg  <= tok_nxt.neg;
      tok_out.num  <= tok_nxt.num;
      tok_out.den  <= tok_nxt.den;
      tok_out.rem  <= tok_nxt.rem;
      tok_out.quo  <= tok_nxt.quo;
    end
  end

endmodule

>>> hw/rtl/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation block.
`timescale 1ns / 1ps
// Turns a raw pressure and temperature count into pascals with 6 fraction
// bits, using a three-point rational calibration set by four signed
// configuration words. One item is accepted per cycle while the pipe
// advances; each result passes 9 front stages, then a chain of 128 divider
// cells that each settle one quotient bit, then the output register. The
// whole pipe advances only when the output register is empty or being taken.
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_pressure[23:0], raw_temperature[39:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // pressure_pa_q6[23:0], status[25:24], zeros
);

  logic signed [15:0] coef_low_r, coef_mid_r, coef_high_r, coef_offset_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_low_r <= '0; coef_mid_r <= '0; coef_high_r <= '0; coef_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LOW:    coef_low_r <= cfg_wdata;
        REG_MID:    coef_mid_r <= cfg_wdata;
        REG_HIGH:   coef_high_r <= cfg_wdata;
        REG_OFFSET: coef_offset_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  div_tok_t chain [DIV_CELLS+1];

  bpc_front u_front (
    .clk, .rst_n, .en,
    .in_vld(in_tvalid),
    .raw_pressure(in_tdata[23:0]),
    .raw_temperature(in_tdata[39:24]),
    .coef_low(coef_low_r), .coef_mid(coef_mid_r),
    .coef_high(coef_high_r), .coef_offset(coef_offset_r),
    .tok(chain[0])
  );

  // Divider chain.
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    bpc_div_cell u_cell (
      .clk, .rst_n, .en, .tok_in(chain[i]), .tok_out(chain[i+1])
    );
  end

  // Final rounding and saturation.
  div_tok_t     fin;
  logic [NUM_W-1:0] q;
  logic [23:0]  pres;
  logic [1:0]   st;
  assign fin = chain[DIV_CELLS];
  always_comb begin
    q = fin.quo + NUM_W'(fin.rem >= (fin.den - fin.rem));
    pres = '0;
    st = ST_OK;
    if (fin.zdiv) st = ST_ZERO_DIV;
    else if (q == '0) st = ST_OK;
    else if (fin.neg) st = ST_SAT;
    else if (q > NUM_W'(OUT_MAX)) begin
      pres = OUT_W'(OUT_MAX);
      st = ST_SAT;
    end else pres = q[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= fin.vld;
    if (en) out_tdata <= {6'b0, st, pres};
  end

endmodule
